### rtl/llq_pkg.sv
// Shared types and constants of the linked list queue manager.
// Holds command codes, pointer and beat structs and the sequencer states.
// No dependencies.
package llq_pkg;

	// Element fields are six bits wide, so at most 64 pool entries are reachable
	localparam int IDX_W = 6;
	localparam int IDX_RANGE = 64;
	localparam int CNT_OUT_W = 7;
	localparam int CNT_CAP = 127;

	typedef enum logic [2:0] {
		CMD_ENQUEUE = 3'd0,
		CMD_DEQUEUE = 3'd1,
		CMD_PUSH    = 3'd2,
		CMD_INSERT  = 3'd3,
		CMD_REMOVE  = 3'd4,
		CMD_COUNT   = 3'd5,
		CMD_EMPTY   = 3'd6
	} cmd_t;

	// Pointer or link: null mark plus element index
	typedef struct packed {
		logic             nul;
		logic [IDX_W-1:0] idx;
	} ptr_t;

	localparam ptr_t NULL_PTR = '{nul: 1'b1, idx: '0};

	typedef struct packed {
		cmd_t             command;
		logic [IDX_W-1:0] element;
		logic [IDX_W-1:0] prev_element;
		logic             prev_none;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]     taken_element;
		logic                 taken_none;
		logic [CNT_OUT_W-1:0] element_count;
		logic                 is_empty;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_WRITE2,
		S_WALK,
		S_RESULT
	} state_t;

endpackage

### rtl/llq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module llq_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/llq_ctrl.sv
// Command sequencer of the linked list queue manager: head/tail pointers,
// read-modify-write of the link memory and the counting walk.
// Depends on llq_pkg.
module llq_ctrl #(
	parameter int POOL_SIZE = 64,
	localparam int DEPTH = (POOL_SIZE < llq_pkg::IDX_RANGE) ? POOL_SIZE : llq_pkg::IDX_RANGE,
	localparam int AW = $clog2(DEPTH),
	localparam int CNT_W = $clog2(POOL_SIZE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  llq_pkg::item_t   item,
	output logic             ready,
	input  logic             res_free,
	output logic             done,
	output llq_pkg::result_t result,
	output logic             we,
	output logic [AW-1:0]    waddr,
	output llq_pkg::ptr_t    wdata,
	output logic             re,
	output logic [AW-1:0]    raddr,
	input  llq_pkg::ptr_t    rdata
);

	function automatic logic [AW-1:0] to_addr(input logic [llq_pkg::IDX_W-1:0] i);
		return AW'(i);
	endfunction

	llq_pkg::state_t st_q, st_d;
	llq_pkg::cmd_t cmd_q;
	logic [llq_pkg::IDX_W-1:0] elem_q;
	llq_pkg::ptr_t pv_q;
	logic eok_q, pok_q;
	llq_pkg::ptr_t head_q, head_d, tail_q, tail_d;
	logic [llq_pkg::IDX_W-1:0] wtgt_q, wtgt_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [llq_pkg::IDX_W-1:0] taken_q, taken_d;
	logic tnone_q, tnone_d;

	llq_pkg::ptr_t e_ptr;
	logic cmd_ok, e_is_head, e_is_tail, ins_append, do_enq, do_push, walk_end;

	// Decode the held command
	always_comb begin
		e_ptr = '{nul: 1'b0, idx: elem_q};
		e_is_head = (head_q == e_ptr);
		e_is_tail = (tail_q == e_ptr);
		ins_append = head_q.nul || (pv_q == tail_q);
		case (cmd_q)
			llq_pkg::CMD_ENQUEUE, llq_pkg::CMD_PUSH: cmd_ok = eok_q;
			llq_pkg::CMD_INSERT, llq_pkg::CMD_REMOVE: cmd_ok = eok_q && pok_q;
			default: cmd_ok = 1'b1;
		endcase
		do_enq = cmd_ok && ((cmd_q == llq_pkg::CMD_ENQUEUE) ||
			(cmd_q == llq_pkg::CMD_INSERT && ins_append));
		do_push = cmd_ok && ((cmd_q == llq_pkg::CMD_PUSH) ||
			(cmd_q == llq_pkg::CMD_INSERT && !ins_append && pv_q.nul));
		walk_end = rdata.nul || (cnt_q == CNT_W'(POOL_SIZE));
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			llq_pkg::S_IDLE: begin
				if (start) st_d = llq_pkg::S_EXEC;
			end
			llq_pkg::S_EXEC: begin
				st_d = llq_pkg::S_RESULT;
				if (do_enq) begin
					if (!head_q.nul && !tail_q.nul) st_d = llq_pkg::S_WRITE2;
				end else if (cmd_ok && !do_push) begin
					case (cmd_q)
						llq_pkg::CMD_DEQUEUE: begin
							if (!head_q.nul) st_d = llq_pkg::S_READ;
						end
						llq_pkg::CMD_INSERT: st_d = llq_pkg::S_READ;
						llq_pkg::CMD_REMOVE: begin
							if (e_is_head || !pv_q.nul) st_d = llq_pkg::S_READ;
						end
						llq_pkg::CMD_COUNT: begin
							if (!head_q.nul) st_d = llq_pkg::S_WALK;
						end
						default: st_d = llq_pkg::S_RESULT;
					endcase
				end
			end
			llq_pkg::S_READ: begin
				st_d = (cmd_q == llq_pkg::CMD_INSERT) ? llq_pkg::S_WRITE2 : llq_pkg::S_RESULT;
			end
			llq_pkg::S_WRITE2: st_d = llq_pkg::S_RESULT;
			llq_pkg::S_WALK: begin
				if (walk_end) st_d = llq_pkg::S_RESULT;
			end
			llq_pkg::S_RESULT: begin
				if (res_free) st_d = llq_pkg::S_IDLE;
			end
			default: st_d = llq_pkg::S_IDLE;
		endcase
	end

	// Memory accesses and pointer updates per state
	always_comb begin
		we = 1'b0;
		waddr = to_addr(elem_q);
		wdata = llq_pkg::NULL_PTR;
		re = 1'b0;
		raddr = to_addr(head_q.idx);
		head_d = head_q;
		tail_d = tail_q;
		wtgt_d = wtgt_q;
		cnt_d = cnt_q;
		taken_d = taken_q;
		tnone_d = tnone_q;
		done = 1'b0;
		case (st_q)
			llq_pkg::S_IDLE: begin
				if (start) begin
					taken_d = '0;
					tnone_d = 1'b1;
					cnt_d = '0;
				end
			end
			llq_pkg::S_EXEC: begin
				if (do_enq) begin
					// Terminate the new element, link it behind the old tail later
					we = 1'b1;
					if (head_q.nul) head_d = e_ptr;
					wtgt_d = tail_q.idx;
					tail_d = e_ptr;
				end else if (do_push) begin
					we = 1'b1;
					wdata = head_q;
					if (head_q.nul) tail_d = e_ptr;
					head_d = e_ptr;
				end else if (cmd_ok) begin
					case (cmd_q)
						llq_pkg::CMD_DEQUEUE: begin
							if (!head_q.nul) begin
								taken_d = head_q.idx;
								tnone_d = 1'b0;
								re = 1'b1;
							end
						end
						llq_pkg::CMD_INSERT: begin
							re = 1'b1;
							raddr = to_addr(pv_q.idx);
						end
						llq_pkg::CMD_REMOVE: begin
							if (e_is_head || !pv_q.nul) begin
								re = 1'b1;
								raddr = to_addr(elem_q);
							end else if (e_is_tail) begin
								tail_d = pv_q;
							end
						end
						llq_pkg::CMD_COUNT: begin
							if (!head_q.nul) begin
								re = 1'b1;
								cnt_d = CNT_W'(1);
							end
						end
						default: ;
					endcase
				end
			end
			llq_pkg::S_READ: begin
				case (cmd_q)
					llq_pkg::CMD_DEQUEUE: begin
						head_d = rdata;
						if (rdata.nul) tail_d = llq_pkg::NULL_PTR;
					end
					llq_pkg::CMD_INSERT: begin
						// New element takes the predecessor's link
						we = 1'b1;
						wdata = rdata;
						wtgt_d = pv_q.idx;
					end
					llq_pkg::CMD_REMOVE: begin
						if (e_is_head) begin
							head_d = rdata;
						end else begin
							we = 1'b1;
							waddr = to_addr(pv_q.idx);
							wdata = rdata;
						end
						if (e_is_tail) tail_d = pv_q;
					end
					default: ;
				endcase
			end
			llq_pkg::S_WRITE2: begin
				we = 1'b1;
				waddr = to_addr(wtgt_q);
				wdata = e_ptr;
			end
			llq_pkg::S_WALK: begin
				// Follow the link just read, one element per cycle
				if (!walk_end) begin
					re = 1'b1;
					raddr = to_addr(rdata.idx);
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			llq_pkg::S_RESULT: done = res_free;
			default: ;
		endcase
	end

	// Control state and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= llq_pkg::S_IDLE;
			head_q <= llq_pkg::NULL_PTR;
			tail_q <= llq_pkg::NULL_PTR;
		end else begin
			st_q <= st_d;
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// Held command beat and working registers
	always_ff @(posedge clk) begin
		if (start && st_q == llq_pkg::S_IDLE) begin
			cmd_q <= item.command;
			elem_q <= item.element;
			pv_q <= item.prev_none ? llq_pkg::NULL_PTR :
				llq_pkg::ptr_t'{nul: 1'b0, idx: item.prev_element};
			eok_q <= 32'(item.element) < 32'(POOL_SIZE);
			pok_q <= item.prev_none || (32'(item.prev_element) < 32'(POOL_SIZE));
		end
		wtgt_q <= wtgt_d;
		cnt_q <= cnt_d;
		taken_q <= taken_d;
		tnone_q <= tnone_d;
	end

	assign ready = (st_q == llq_pkg::S_IDLE);

	always_comb begin
		result.taken_element = taken_q;
		result.taken_none = tnone_q;
		result.element_count = (32'(cnt_q) > 32'(llq_pkg::CNT_CAP)) ?
			llq_pkg::CNT_OUT_W'(llq_pkg::CNT_CAP) : llq_pkg::CNT_OUT_W'(cnt_q);
		result.is_empty = head_q.nul;
	end

	// The sequencer never reads and writes the same link in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && waddr == raddr))
		else $error("link read and write collide");

	// The walk count stays within the pool
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == llq_pkg::S_WALK |-> (cnt_q != '0 && 32'(cnt_q) <= 32'(POOL_SIZE)))
		else $error("walk count out of range");

	// An accepted beat starts execution with its command held
	a_start_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && ready |=> (st_q == llq_pkg::S_EXEC && cmd_q == $past(item.command)))
		else $error("accepted command not executed");

endmodule

### rtl/linked_list_queue_manager_unit.sv
// Singly linked queue manager over a pool of element indices.
//
// Item channel (item_valid / item_stall) carries one command beat: command,
// element, prev_element, prev_none. Result channel (result_valid /
// result_stall) returns exactly one beat per command: taken_element,
// taken_none, element_count, is_empty.
// One command is worked at a time; the link memory (one write port, one
// registered read port) sets the pace. Push, empty query, unused or rejected
// commands, dequeue and count of an empty queue, enqueue with a null tail and
// a remove that needs no link go from S_EXEC straight to S_RESULT; dequeue and
// a remove that reads a link pass S_READ, enqueue behind a tail S_WRITE2, and
// insert in the middle S_READ then S_WRITE2 (insert at either end runs as push
// or enqueue); count walks N linked elements in S_WALK (N at most POOL_SIZE).
// A new command is accepted in the cycle after the result is loaded, even
// while that result still waits to be taken.
// Reset clears head and tail to null; link entries stay undefined until
// written and need no clearing. While result_stall is high a held result beat
// stays, and a finished command waits in S_RESULT until that beat is taken.
// Depends on llq_pkg, llq_ctrl, llq_ram.
module linked_list_queue_manager_unit #(
	parameter int POOL_SIZE = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [2:0]                          command,
	input  logic [llq_pkg::IDX_W-1:0]           element,
	input  logic [llq_pkg::IDX_W-1:0]           prev_element,
	input  logic                                prev_none,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [llq_pkg::IDX_W-1:0]           taken_element,
	output logic                                taken_none,
	output logic [llq_pkg::CNT_OUT_W-1:0]       element_count,
	output logic                                is_empty
);

	localparam int DEPTH = (POOL_SIZE < llq_pkg::IDX_RANGE) ? POOL_SIZE : llq_pkg::IDX_RANGE;
	localparam int AW = $clog2(DEPTH);

	llq_pkg::item_t item;
	llq_pkg::result_t res, out_q;
	logic ready, done, res_free, out_valid_q;
	logic we, re;
	logic [AW-1:0] waddr, raddr;
	llq_pkg::ptr_t wdata, rdata;

	// Pack the command beat
	always_comb begin
		item.command = llq_pkg::cmd_t'(command);
		item.element = element;
		item.prev_element = prev_element;
		item.prev_none = prev_none;
	end

	assign item_stall = !ready;
	assign res_free = !out_valid_q || !result_stall;

	llq_ctrl #(
		.POOL_SIZE(POOL_SIZE)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(item_valid),
		.item(item),
		.ready(ready),
		.res_free(res_free),
		.done(done),
		.result(res),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	llq_ram #(
		.WIDTH($bits(llq_pkg::ptr_t)),
		.DEPTH(DEPTH)
	) u_links (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Result beat register: load on completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign taken_element = out_q.taken_element;
	assign taken_none = out_q.taken_none;
	assign element_count = out_q.element_count;
	assign is_empty = out_q.is_empty;

endmodule

### verif/llq_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the linked list queue manager testbench: a shadow copy of
// the link memory, head and tail, and the result beats still owed by the block.
// Depends on llq_pkg.
package llq_tb_pkg;
	import llq_pkg::*;

	// Pool size of the block under test; six-bit element fields cover all of it
	localparam int POOL = IDX_RANGE;
	// Command code with no operation behind it
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	class llq_scoreboard;
		ptr_t    next_link [POOL];
		bit      link_set [POOL];
		ptr_t    head;
		ptr_t    tail;
		result_t expected_beats [$];
		int      mismatches;
		int      beats_checked;
		int      cmd_tally [8];

		function new();
			head = NULL_PTR;
			tail = NULL_PTR;
			foreach (link_set[i]) begin
				link_set[i] = 1'b0;
				next_link[i] = NULL_PTR;
			end
			foreach (cmd_tally[i]) cmd_tally[i] = 0;
			mismatches = 0;
			beats_checked = 0;
		endfunction

		// Write a link; a null pointer has no entry behind it
		function void set_link(ptr_t p, ptr_t v);
			if (!p.nul) begin
				next_link[p.idx] = v;
				link_set[p.idx] = 1'b1;
			end
		endfunction

		function void append_elem(ptr_t e);
			set_link(e, NULL_PTR);
			if (head.nul) head = e;
			else set_link(tail, e);
			tail = e;
		endfunction

		function void push_elem(ptr_t e);
			set_link(e, head);
			if (head.nul) tail = e;
			head = e;
		endfunction

		// Work out the result beat of one command and advance the shadow state
		function result_t apply_command(item_t it);
			ptr_t    e;
			ptr_t    pv;
			ptr_t    walk_p;
			int      n;
			result_t r;
			e = '{nul: 1'b0, idx: it.element};
			if (it.prev_none) pv = NULL_PTR;
			else pv = '{nul: 1'b0, idx: it.prev_element};
			r = '0;
			r.taken_none = 1'b1;
			case (it.command)
				CMD_ENQUEUE: append_elem(e);
				CMD_DEQUEUE: begin
					if (!head.nul) begin
						r.taken_element = head.idx;
						r.taken_none = 1'b0;
						head = next_link[head.idx];
						if (head.nul) tail = NULL_PTR;
					end
				end
				CMD_PUSH: push_elem(e);
				CMD_INSERT: begin
					if (head.nul || pv == tail) append_elem(e);
					else if (pv.nul) push_elem(e);
					else begin
						set_link(e, next_link[pv.idx]);
						set_link(pv, e);
					end
				end
				CMD_REMOVE: begin
					if (e == head) head = next_link[e.idx];
					else if (!pv.nul) set_link(pv, next_link[e.idx]);
					if (e == tail) tail = pv;
				end
				CMD_COUNT: begin
					// walk stops at the pool size, so a cycle saturates
					walk_p = head;
					n = 0;
					while (!walk_p.nul && n < POOL) begin
						n++;
						walk_p = next_link[walk_p.idx];
					end
					r.element_count = CNT_OUT_W'(n);
				end
				default: ;
			endcase
			r.is_empty = head.nul;
			return r;
		endfunction

		// Elements reachable from the head, in queue order, at most one pool's worth
		function void list_order(output ptr_t order [$]);
			ptr_t p;
			order.delete();
			p = head;
			while (!p.nul && order.size() < POOL) begin
				order.push_back(p);
				p = next_link[p.idx];
			end
		endfunction

		// Steer a command away from reading a link entry that was never written
		function item_t make_safe(item_t it);
			ptr_t e;
			ptr_t pv;
			int   written [$];
			bit   risky;
			e = '{nul: 1'b0, idx: it.element};
			pv = '{nul: 1'b0, idx: it.prev_element};
			risky = 1'b0;
			if (it.command == CMD_REMOVE)
				risky = e != head && !it.prev_none && !link_set[it.element];
			if (it.command == CMD_INSERT)
				risky = !head.nul && !it.prev_none && pv != tail && !link_set[it.prev_element];
			if (!risky) return it;
			foreach (link_set[i]) if (link_set[i]) written.push_back(i);
			if (written.size() == 0) it.command = CMD_ENQUEUE;
			else if (it.command == CMD_REMOVE)
				it.element = IDX_W'(written[$urandom_range(0, written.size() - 1)]);
			else it.prev_element = IDX_W'(written[$urandom_range(0, written.size() - 1)]);
			return it;
		endfunction

		function void note_command(item_t it);
			cmd_tally[it.command]++;
			expected_beats.push_back(apply_command(it));
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (expected_beats.size() == 0) begin
				$error("result beat with no command outstanding");
				mismatches++;
				return;
			end
			want = expected_beats.pop_front();
			beats_checked++;
			if (got.taken_element !== want.taken_element) begin
				$error("taken_element: expected %0d, actual %0d", want.taken_element,
					got.taken_element);
				mismatches++;
			end
			if (got.taken_none !== want.taken_none) begin
				$error("taken_none: expected %0d, actual %0d", want.taken_none, got.taken_none);
				mismatches++;
			end
			if (got.element_count !== want.element_count) begin
				$error("element_count: expected %0d, actual %0d", want.element_count,
					got.element_count);
				mismatches++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

endpackage

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for linked_list_queue_manager_unit: directed and random command
// beats with bursty sending and a stalling receiver, checked by the scoreboard.
// Depends on llq_pkg, llq_tb_pkg and the block's RTL.
module tb;
	import llq_pkg::*;
	import llq_tb_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	logic [2:0]           command;
	logic [IDX_W-1:0]     element;
	logic [IDX_W-1:0]     prev_element;
	logic                 prev_none;
	logic                 result_valid;
	logic                 result_stall;
	logic [IDX_W-1:0]     taken_element;
	logic                 taken_none;
	logic [CNT_OUT_W-1:0] element_count;
	logic                 is_empty;

	llq_scoreboard sb = new();
	int hold_requests = 0;
	int quiet_cycles = 0;
	int sent_total = 0;

	linked_list_queue_manager_unit #(.POOL_SIZE(POOL)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.element(element),
		.prev_element(prev_element),
		.prev_none(prev_none),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.taken_element(taken_element),
		.taken_none(taken_none),
		.element_count(element_count),
		.is_empty(is_empty)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic item_t cmd_beat(logic [2:0] cmd, int e, int pv, bit pn);
		item_t it;
		it.command = cmd_t'(cmd);
		it.element = IDX_W'(e);
		it.prev_element = IDX_W'(pv);
		it.prev_none = pn;
		return it;
	endfunction

	// Pick an element not already linked, giving up after a few tries
	function automatic logic [IDX_W-1:0] fresh_element(ptr_t order [$]);
		logic [IDX_W-1:0] cand;
		bit               seen;
		cand = IDX_W'($urandom_range(0, POOL - 1));
		repeat (8) begin
			seen = 1'b0;
			foreach (order[j]) if (order[j].idx == cand) seen = 1'b1;
			if (!seen) return cand;
			cand = IDX_W'($urandom_range(0, POOL - 1));
		end
		return cand;
	endfunction

	// Mostly well-formed commands against the current list, some raw noise
	function automatic item_t random_command();
		ptr_t  order [$];
		item_t it;
		int    pick;
		int    k;
		sb.list_order(order);
		pick = $urandom_range(0, 99);
		// drain a nearly full list more often than growing it
		if (order.size() > 48 && pick < 64 && $urandom_range(0, 1)) pick = 30;
		it.element = IDX_W'($urandom_range(0, POOL - 1));
		it.prev_element = IDX_W'($urandom_range(0, POOL - 1));
		it.prev_none = 1'($urandom_range(0, 1));
		if (pick < 22) it.command = CMD_ENQUEUE;
		else if (pick < 40) it.command = CMD_DEQUEUE;
		else if (pick < 50) it.command = CMD_PUSH;
		else if (pick < 64) it.command = CMD_INSERT;
		else if (pick < 80) it.command = CMD_REMOVE;
		else if (pick < 89) it.command = CMD_COUNT;
		else if (pick < 96) it.command = CMD_EMPTY;
		else it.command = cmd_t'(CMD_UNUSED);
		if ($urandom_range(0, 9) < 8) begin
			if (it.command == CMD_ENQUEUE || it.command == CMD_PUSH || it.command == CMD_INSERT)
				it.element = fresh_element(order);
			if (it.command == CMD_INSERT) begin
				k = $urandom_range(0, order.size());
				it.prev_none = (k == 0);
				if (k > 0) it.prev_element = order[k - 1].idx;
			end
			if (it.command == CMD_REMOVE && order.size() > 0) begin
				k = $urandom_range(0, order.size() - 1);
				it.element = order[k].idx;
				it.prev_none = (k == 0);
				if (k > 0) it.prev_element = order[k - 1].idx;
			end
		end
		return sb.make_safe(it);
	endfunction

	// Offer one command beat and hold it until accepted
	task automatic send_item(input item_t it);
		@(negedge clk);
		item_valid <= 1'b1;
		command <= it.command;
		element <= it.element;
		prev_element <= it.prev_element;
		prev_none <= it.prev_none;
		do @(posedge clk); while (item_stall);
		sb.note_command(it);
		sent_total++;
	endtask

	task automatic pause_items(input int cycles);
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending until every owed result beat has come back
	task automatic wait_drain();
		pause_items(1);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Receiver: long hold-offs on request, otherwise a changing stall pattern
	initial begin : result_stall_gen
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_served;
		int       phase;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		hold_served = 0;
		phase = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_FREE: result_stall <= 1'b0;
					RX_RANDOM: result_stall <= ($urandom_range(0, 99) < 35);
					default: result_stall <= (phase % 16 < 5);
				endcase
			end
		end
	end

	// Check each result beat as it is taken
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_beat(result_t'{taken_element: taken_element, taken_none: taken_none,
				element_count: element_count, is_empty: is_empty});
	end

	// Abort when neither channel moves a beat for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		item_t directed_q [$];
		int    burst_left;
		int    gap;
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = '0;
		element = '0;
		prev_element = '0;
		prev_none = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Empty-queue answers, every command, edge positions, null tail, cycles
		directed_q = '{
			cmd_beat(CMD_EMPTY, 0, 0, 0),
			cmd_beat(CMD_DEQUEUE, 63, 63, 1),
			cmd_beat(CMD_COUNT, 0, 0, 1),
			cmd_beat(CMD_UNUSED, 63, 63, 1),
			cmd_beat(CMD_INSERT, 0, 30, 0),
			cmd_beat(CMD_ENQUEUE, 63, 0, 0),
			cmd_beat(CMD_PUSH, 21, 0, 0),
			cmd_beat(CMD_INSERT, 42, 0, 1),
			cmd_beat(CMD_INSERT, 10, 0, 0),
			cmd_beat(CMD_INSERT, 33, 63, 0),
			cmd_beat(CMD_COUNT, 0, 0, 0),
			cmd_beat(CMD_REMOVE, 10, 0, 0),
			cmd_beat(CMD_REMOVE, 42, 0, 1),
			cmd_beat(CMD_REMOVE, 33, 63, 0),
			cmd_beat(CMD_ENQUEUE, 5, 0, 0),
			cmd_beat(CMD_DEQUEUE, 0, 0, 0),
			cmd_beat(CMD_DEQUEUE, 0, 0, 0),
			cmd_beat(CMD_REMOVE, 5, 0, 1),
			cmd_beat(CMD_ENQUEUE, 7, 0, 0),
			cmd_beat(CMD_DEQUEUE, 0, 0, 0),
			cmd_beat(CMD_DEQUEUE, 0, 0, 0),
			cmd_beat(CMD_ENQUEUE, 9, 0, 0),
			cmd_beat(CMD_ENQUEUE, 9, 0, 0),
			cmd_beat(CMD_COUNT, 0, 0, 0),
			cmd_beat(CMD_PUSH, 4, 0, 0),
			cmd_beat(CMD_ENQUEUE, 8, 0, 0),
			cmd_beat(CMD_COUNT, 0, 0, 0)
		};
		foreach (directed_q[i]) send_item(sb.make_safe(directed_q[i]));
		wait_drain();

		// Random bursts; two long receiver hold-offs and one full drain midway
		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300 || n == 1000) hold_requests++;
			if (n == 700) wait_drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) pause_items(gap);
			end
			burst_left--;
			send_item(random_command());
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d commands, checked %0d result beats, %0d mismatches",
			sent_total, sb.beats_checked, sb.mismatches);
		$display("Mix: enq %0d deq %0d push %0d ins %0d rem %0d cnt %0d empty %0d unused %0d",
			sb.cmd_tally[CMD_ENQUEUE], sb.cmd_tally[CMD_DEQUEUE], sb.cmd_tally[CMD_PUSH],
			sb.cmd_tally[CMD_INSERT], sb.cmd_tally[CMD_REMOVE], sb.cmd_tally[CMD_COUNT],
			sb.cmd_tally[CMD_EMPTY], sb.cmd_tally[CMD_UNUSED]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
